### rtl/core/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants for the longest-prefix-match router.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    localparam int DEF_MAX_ROUTES = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int ADDR_BITS      = 32;
    localparam int LEN_BITS       = 6;
    localparam int PORT_BITS      = 3;
    localparam int TTL_BITS       = 8;
    localparam int STATUS_BITS    = 3;

    localparam logic [LEN_BITS-1:0] MAX_PREFIX_LEN = LEN_BITS'(31 + 1);
    localparam logic [TTL_BITS-1:0] TTL_MIN        = TTL_BITS'(8'h01);

    localparam logic [STATUS_BITS-1:0] ST_FORWARDED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DROP_TTL  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_ROUTE  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ADDED     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DROP_TTL,
        OP_LOOKUP
    } op_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [LEN_BITS-1:0]  len;
        logic [ADDR_BITS-1:0] gateway;
        logic                 direct;
        logic [PORT_BITS-1:0] port;
    } entry_t;

    typedef struct packed {
        op_t                  op;
        entry_t               entry;
        logic [ADDR_BITS-1:0] dest;
        logic [TTL_BITS-1:0]  ttl_dec;
    } cmd_t;

endpackage

### rtl/core/lpmr_req_if.sv
// ----------------------------------------------------------------------------
// lpmr_req_if
// Request channel: route add or datagram lookup.
// ----------------------------------------------------------------------------
interface lpmr_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] prefix_value;
    logic [5:0]  prefix_bits;
    logic        has_gateway;
    logic [31:0] gateway_addr;
    logic [2:0]  port_index;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;

    modport source (
        output valid, mode, prefix_value, prefix_bits, has_gateway,
               gateway_addr, port_index, dest_addr, ttl_in,
        input  ready
    );

    modport sink (
        input  valid, mode, prefix_value, prefix_bits, has_gateway,
               gateway_addr, port_index, dest_addr, ttl_in,
        output ready
    );
endinterface

### rtl/core/lpmr_rsp_if.sv
// ----------------------------------------------------------------------------
// lpmr_rsp_if
// Response channel: status, interface, next hop and TTL.
// ----------------------------------------------------------------------------
interface lpmr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  out_port;
    logic [31:0] hop_addr;
    logic [7:0]  ttl_out;

    modport source (
        output valid, status, out_port, hop_addr, ttl_out,
        input  ready
    );

    modport sink (
        input  valid, status, out_port, hop_addr, ttl_out,
        output ready
    );
endinterface

### rtl/core/lpmr_front.sv
// ----------------------------------------------------------------------------
// lpmr_front
// Accepts requests, classifies them and forms commands for the queue.
// ----------------------------------------------------------------------------
module lpmr_front (
    input  logic              clk,
    input  logic              rst_n,
    lpmr_req_if.sink          req,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output lpmr_pkg::cmd_t    cmd
);
    import lpmr_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign req.ready = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.entry.prefix  = req.prefix_value;
        cmd_next.entry.len     = (req.prefix_bits > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                                    : req.prefix_bits;
        cmd_next.entry.gateway = req.has_gateway ? req.gateway_addr : '0;
        cmd_next.entry.direct  = !req.has_gateway;
        cmd_next.entry.port    = req.port_index;
        cmd_next.dest          = req.dest_addr;
        cmd_next.ttl_dec       = req.ttl_in - TTL_MIN;
        if (!req.mode)
        begin
            cmd_next.op = OP_ADD;
        end
        else if (req.ttl_in <= TTL_MIN)
        begin
            cmd_next.op = OP_DROP_TTL;
        end
        else
        begin
            cmd_next.op = OP_LOOKUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

### rtl/core/lpmr_queue.sv
// ----------------------------------------------------------------------------
// lpmr_queue
// Short command queue between the front and back.
// ----------------------------------------------------------------------------
module lpmr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpmr_pkg::cmd_t    in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output lpmr_pkg::cmd_t    out_cmd
);
    import lpmr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/core/lpmr_back.sv
// ----------------------------------------------------------------------------
// lpmr_back
// Route table, sequential prefix scan and response register.
// ----------------------------------------------------------------------------
module lpmr_back #(
    parameter int MAX_ROUTES = lpmr_pkg::DEF_MAX_ROUTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  lpmr_pkg::cmd_t    cmd,
    lpmr_rsp_if.source        rsp
);
    import lpmr_pkg::*;

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg;
    entry_t                 table_mem [MAX_ROUTES];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic [ADDR_BITS-1:0]   dest_reg;
    logic [TTL_BITS-1:0]    ttl_reg;
    logic                   found_reg;
    logic [LEN_BITS-1:0]    best_len_reg;
    logic [PORT_BITS-1:0]   best_port_reg;
    logic [ADDR_BITS-1:0]   best_hop_reg;
    logic                   rsp_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [PORT_BITS-1:0]   port_reg;
    logic [ADDR_BITS-1:0]   hop_reg;
    logic [TTL_BITS-1:0]    ttl_out_reg;

    logic                   out_free;
    logic                   table_full;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   mask;
    logic                   take;
    logic                   rsp_load;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.out_port = port_reg;
    assign rsp.hop_addr = hop_reg;
    assign rsp.ttl_out  = ttl_out_reg;

    always_comb
    begin
        out_free   = !rsp_valid_reg || rsp.ready;
        table_full = count_reg == CNT_W'(MAX_ROUTES);
        cmd_ready  = (state_reg == S_IDLE) && ((cmd.op == OP_LOOKUP) || out_free);
        wr_en      = cmd_valid && cmd_ready && (cmd.op == OP_ADD) && !table_full;
        rd_en      = (state_reg == S_SCAN) && (scan_idx_reg < count_reg);
        mask       = ~({ADDR_BITS{1'b1}} >> rd_data_reg.len);
        take       = rd_valid_reg && (((rd_data_reg.prefix ^ dest_reg) & mask) == '0)
                     && (!found_reg || (rd_data_reg.len > best_len_reg));
        rsp_load   = ((state_reg == S_IDLE) && cmd_valid && cmd_ready && (cmd.op != OP_LOOKUP))
                     || ((state_reg == S_DONE) && out_free);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= cmd.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            rd_valid_reg <= rd_en;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        case (cmd.op)
                            OP_ADD:
                            begin
                                status_reg    <= table_full ? ST_FULL : ST_ADDED;
                                port_reg      <= '0;
                                hop_reg       <= '0;
                                ttl_out_reg   <= '0;
                                if (!table_full)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_LOOKUP:
                            begin
                                dest_reg     <= cmd.dest;
                                ttl_reg      <= cmd.ttl_dec;
                                found_reg    <= 1'b0;
                                scan_idx_reg <= '0;
                                state_reg    <= S_SCAN;
                            end
                            default:
                            begin
                                status_reg    <= ST_DROP_TTL;
                                port_reg      <= '0;
                                hop_reg       <= '0;
                                ttl_out_reg   <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        best_len_reg  <= rd_data_reg.len;
                        best_port_reg <= rd_data_reg.port;
                        best_hop_reg  <= rd_data_reg.direct ? dest_reg : rd_data_reg.gateway;
                    end
                    if (!rd_en && !rd_valid_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        status_reg    <= found_reg ? ST_FORWARDED : ST_NO_ROUTE;
                        port_reg      <= found_reg ? best_port_reg : '0;
                        hop_reg       <= found_reg ? best_hop_reg : '0;
                        ttl_out_reg   <= found_reg ? ttl_reg : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROUTES))
        else $error("route count above table size");

    a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("route table changed during scan");

    a_drop_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != ST_FORWARDED))
        |-> (port_reg == '0 && hop_reg == '0 && ttl_out_reg == '0))
        else $error("nonzero payload on non-forwarded response");

    a_fwd_ttl_live: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_FORWARDED)) |-> (ttl_out_reg != '0))
        else $error("forwarded datagram with expired ttl");

endmodule

### rtl/core/longest_prefix_match_router_unit.sv
// ----------------------------------------------------------------------------
// longest_prefix_match_router_unit
// IPv4 route table with longest-prefix-match forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per valid/ready handshake. mode 0 appends a
//   route (status 3 added, 4 table full); mode 1 routes a datagram (status 0
//   forwarded, 1 ttl expired, 2 no route). rsp returns exactly one response
//   per request, in request order.
// Throughput:
//   Add and ttl-drop requests pass the front register, queue and response
//   register and sustain one per cycle while rsp.ready is high. A lookup
//   scans the stored routes one per cycle through the table read port,
//   then the next queued request starts.
// Reset:
//   rst_n clears the route count and all handshake state; table contents
//   are not cleared and only entries below the count are read.
// Backpressure:
//   With rsp.ready low the response register holds; a two-entry queue and
//   the front register keep taking requests until full, then req.ready drops.
// ----------------------------------------------------------------------------
module longest_prefix_match_router_unit #(
    parameter int MAX_ROUTES = lpmr_pkg::DEF_MAX_ROUTES
) (
    input  logic       clk,
    input  logic       rst_n,
    lpmr_req_if.sink   req,
    lpmr_rsp_if.source rsp
);
    import lpmr_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    lpmr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    lpmr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    lpmr_back #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .rsp       (rsp)
    );

endmodule

### verif/longest_prefix_match_router_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_prefix_match_router_unit_tb
// Drives route adds and datagram lookups into the router. A table model
// predicts every response: the longest matching prefix wins, and on equal
// lengths the earliest route wins. Both sides stall in random bursts.
// ----------------------------------------------------------------------------

typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_ROUTE = 1'b1
} req_mode_t;

typedef struct packed {
    req_mode_t                      mode;
    logic [lpmr_pkg::ADDR_BITS-1:0] prefix_value;
    logic [lpmr_pkg::LEN_BITS-1:0]  prefix_bits;
    logic                           has_gateway;
    logic [lpmr_pkg::ADDR_BITS-1:0] gateway_addr;
    logic [lpmr_pkg::PORT_BITS-1:0] port_index;
    logic [lpmr_pkg::ADDR_BITS-1:0] dest_addr;
    logic [lpmr_pkg::TTL_BITS-1:0]  ttl_in;
} route_req_t;

typedef struct packed {
    logic [lpmr_pkg::STATUS_BITS-1:0] status;
    logic [lpmr_pkg::PORT_BITS-1:0]   out_port;
    logic [lpmr_pkg::ADDR_BITS-1:0]   hop_addr;
    logic [lpmr_pkg::TTL_BITS-1:0]    ttl_out;
} route_rsp_t;

class route_table_checker;
    lpmr_pkg::entry_t routes [lpmr_pkg::DEF_MAX_ROUTES];
    int               route_count;
    route_rsp_t       owed_responses [$];
    int               mismatch_count;

    function new();
        route_count    = 0;
        mismatch_count = 0;
    endfunction

    static function logic [31:0] prefix_mask(logic [5:0] len);
        return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function void note_request(route_req_t r);
        route_rsp_t rsp;
        int         best;
        rsp  = '0;
        best = -1;
        if (r.mode == MODE_ADD)
        begin
            if (route_count >= lpmr_pkg::DEF_MAX_ROUTES)
            begin
                rsp.status = lpmr_pkg::ST_FULL;
            end
            else
            begin
                routes[route_count].prefix  = r.prefix_value;
                routes[route_count].len     = (r.prefix_bits > lpmr_pkg::MAX_PREFIX_LEN) ?
                                              lpmr_pkg::MAX_PREFIX_LEN : r.prefix_bits;
                routes[route_count].gateway = r.has_gateway ? r.gateway_addr : '0;
                routes[route_count].direct  = !r.has_gateway;
                routes[route_count].port    = r.port_index;
                route_count++;
                rsp.status = lpmr_pkg::ST_ADDED;
            end
        end
        else if (r.ttl_in <= lpmr_pkg::TTL_MIN)
        begin
            rsp.status = lpmr_pkg::ST_DROP_TTL;
        end
        else
        begin
            for (int i = 0; i < route_count; i++)
            begin
                if (((routes[i].prefix ^ r.dest_addr) & prefix_mask(routes[i].len)) == 0 &&
                    (best < 0 || routes[i].len > routes[best].len))
                    best = i;
            end
            if (best < 0)
            begin
                rsp.status = lpmr_pkg::ST_NO_ROUTE;
            end
            else
            begin
                rsp.status   = lpmr_pkg::ST_FORWARDED;
                rsp.out_port = routes[best].port;
                rsp.hop_addr = routes[best].direct ? r.dest_addr : routes[best].gateway;
                rsp.ttl_out  = r.ttl_in - 8'd1;
            end
        end
        owed_responses = {owed_responses, rsp};
    endfunction

    task report(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task check_response(route_rsp_t got);
        route_rsp_t want;
        if (owed_responses.size() == 0)
        begin
            report("response with no request outstanding");
            return;
        end
        want = owed_responses.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.out_port !== want.out_port)
            report($sformatf("out_port %0d, expected %0d", got.out_port, want.out_port));
        if (got.hop_addr !== want.hop_addr)
            report($sformatf("hop_addr %08h, expected %08h", got.hop_addr, want.hop_addr));
        if (got.ttl_out !== want.ttl_out)
            report($sformatf("ttl_out %0d, expected %0d", got.ttl_out, want.ttl_out));
    endtask
endclass

module longest_prefix_match_router_unit_tb;
    import lpmr_pkg::*;

    localparam int MAX_ROUTES   = DEF_MAX_ROUTES;
    localparam int RANDOM_ITEMS = 780;
    localparam int CALM_ITEMS   = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 48;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lpmr_req_if req_ch ();
    lpmr_rsp_if rsp_ch ();

    longest_prefix_match_router_unit #(
        .MAX_ROUTES (MAX_ROUTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    route_table_checker sb;
    bit                 idle_on;
    int                 quiet_cycles;
    int                 stall_left;
    route_rsp_t         seen;

    always #6 clk = ~clk;

    task automatic drive_fields(input route_req_t r);
        req_ch.mode         = r.mode;
        req_ch.prefix_value = r.prefix_value;
        req_ch.prefix_bits  = r.prefix_bits;
        req_ch.has_gateway  = r.has_gateway;
        req_ch.gateway_addr = r.gateway_addr;
        req_ch.port_index   = r.port_index;
        req_ch.dest_addr    = r.dest_addr;
        req_ch.ttl_in       = r.ttl_in;
    endtask

    task automatic send_request(input route_req_t r);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap          = $urandom_range(1, 11);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        drive_fields(r);
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(r);
    endtask

    function automatic route_req_t add_req(logic [31:0] prefix, logic [5:0] bits,
                                           logic has_gw, logic [31:0] gw, logic [2:0] port);
        route_req_t r;
        r.mode         = MODE_ADD;
        r.prefix_value = prefix;
        r.prefix_bits  = bits;
        r.has_gateway  = has_gw;
        r.gateway_addr = gw;
        r.port_index   = port;
        r.dest_addr    = $urandom;
        r.ttl_in       = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic route_req_t route_req(logic [31:0] dest, logic [7:0] ttl);
        route_req_t r;
        r.mode         = MODE_ROUTE;
        r.prefix_value = $urandom;
        r.prefix_bits  = 6'($urandom_range(0, 63));
        r.has_gateway  = 1'($urandom_range(0, 1));
        r.gateway_addr = $urandom;
        r.port_index   = 3'($urandom_range(0, 7));
        r.dest_addr    = dest;
        r.ttl_in       = ttl;
        return r;
    endfunction

    // Mostly lookups aimed inside stored prefixes; adds often nest under an
    // existing route. A default route only goes into the last free slot so
    // that no-route drops stay reachable while the table fills.
    function automatic route_req_t random_request();
        route_req_t       r;
        lpmr_pkg::entry_t base;
        logic [31:0]      keep;
        r              = route_req($urandom, 8'($urandom_range(0, 255)));
        r.prefix_bits  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(1, 32));
        if (sb.route_count > 0)
        begin
            base = sb.routes[$urandom_range(0, sb.route_count - 1)];
            keep = sb.prefix_mask(base.len);
        end
        else
        begin
            base = '0;
            keep = '0;
        end
        if ($urandom_range(0, 99) < 18)
        begin
            r.mode = MODE_ADD;
            if (sb.route_count == MAX_ROUTES - 1)
            begin
                r.prefix_bits = '0;
            end
            else
            begin
                if (r.prefix_bits == 0)
                    r.prefix_bits = 6'd24;
                if ($urandom_range(0, 1) == 1)
                    r.prefix_value = (base.prefix & keep) | (r.prefix_value & ~keep);
            end
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                r.ttl_in = 8'($urandom_range(0, 1));
            else if ($urandom_range(0, 9) == 0)
                r.ttl_in = 8'hFF;
            if ($urandom_range(0, 3) != 0)
                r.dest_addr = (base.prefix & keep) | (r.dest_addr & ~keep);
        end
        return r;
    endfunction

    task automatic run_directed();
        send_request(route_req(32'hC0A8_0001, 8'd64));
        send_request(route_req(32'hFFFF_FFFF, 8'd0));
        send_request(route_req(32'h0000_0000, 8'd1));
        send_request(add_req(32'h0A00_0000, 6'd8,  1'b0, 32'hDEAD_BEEF, 3'd3));
        send_request(add_req(32'h0A7F_0000, 6'd8,  1'b1, 32'hC000_0001, 3'd4));
        send_request(add_req(32'hFFFF_FFFF, 6'h3F, 1'b0, 32'hFFFF_FFFF, 3'd0));
        send_request(add_req(32'h0000_0000, 6'd32, 1'b1, 32'hFFFF_FFFF, 3'd7));
        send_request(add_req(32'h0A0B_0000, 6'd16, 1'b1, 32'h0A00_0001, 3'd5));
        send_request(add_req(32'h8000_0000, 6'd33, 1'b1, 32'h0000_0000, 3'd6));
        send_request(route_req(32'h0A01_0203, 8'd255));
        send_request(route_req(32'h0A0B_0C0D, 8'd2));
        send_request(route_req(32'hFFFF_FFFF, 8'd2));
        send_request(route_req(32'h0000_0000, 8'd128));
        send_request(route_req(32'h8000_0000, 8'd3));
        send_request(route_req(32'h8000_0001, 8'd3));
        send_request(route_req(32'h0A0B_0C0D, 8'd1));
        send_request(route_req(32'h7FFF_FFFF, 8'd200));
    endtask

    initial
    begin
        sb           = new();
        idle_on      = 1'b1;
        req_ch.valid = 1'b0;
        drive_fields('0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on = (i < RANDOM_ITEMS - CALM_ITEMS);
            send_request(random_request());
        end
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.owed_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("longest_prefix_match_router_unit verification clean");
        else
            $display("longest_prefix_match_router_unit verification failed");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.status   = rsp_ch.status;
                seen.out_port = rsp_ch.out_port;
                seen.hop_addr = rsp_ch.hop_addr;
                seen.ttl_out  = rsp_ch.ttl_out;
                sb.check_response(seen);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("longest_prefix_match_router_unit verification failed");
                $finish;
            end
        end
        else
        begin
            quiet_cycles = 0;
        end
    end

endmodule

### filelist.f
rtl/core/lpmr_pkg.sv
rtl/core/lpmr_req_if.sv
rtl/core/lpmr_rsp_if.sv
rtl/core/lpmr_front.sv
rtl/core/lpmr_queue.sv
rtl/core/lpmr_back.sv
rtl/core/longest_prefix_match_router_unit.sv
verif/longest_prefix_match_router_unit_tb.sv
